// ----- sv/ncst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncst_pkg: shared types and constants of the named semaphore table
// The request token that travels down the cell chain, the claim broadcast
// and the count limits live here.
// ----------------------------------------------------------------------------
package ncst_pkg;

    localparam int NUM_SEMAPHORES_DEF = 16;
    localparam int NAME_BYTES_DEF     = 8;

    // Entry indexes travel at the width of a semaphore id.
    localparam int ID_W    = 8;
    localparam int NAME_W  = 64;
    localparam int COUNT_W = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN  = 16'sh8000;
    localparam logic signed [COUNT_W-1:0] FAIL_VALUE = -16'sd1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_SET    = 2'd1,
        KIND_WAIT   = 2'd2,
        KIND_SIGNAL = 2'd3
    } t_kind;

    // Request token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                      valid;
        t_kind                     kind;
        logic [ID_W-1:0]           sem_id;
        logic [NAME_W-1:0]         name;
        logic signed [COUNT_W-1:0] new_count;
        logic                      found;      // a used entry matched the name
        logic [ID_W-1:0]           found_idx;
        logic                      free;       // a free entry was seen
        logic [ID_W-1:0]           free_idx;
        logic                      done;       // set, wait or signal applied
        logic signed [COUNT_W-1:0] value;
        logic                      block;
        logic                      wake;
    } t_tok;

    // Broadcast that claims a free entry for a newly created name.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   idx;
        logic [NAME_W-1:0] name;
    } t_claim;

endpackage
`default_nettype wire

// ----- sv/ncst_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ncst_cell: one semaphore entry of the table
// Holds one entry, applies the passing request token to it and registers the
// token for the next cell.
// ----------------------------------------------------------------------------
module ncst_cell #(
    parameter int IDX = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ncst_pkg::t_tok   i_tok,
    input  wire ncst_pkg::t_claim i_claim,
    output ncst_pkg::t_tok        o_tok
);

    localparam logic [ncst_pkg::ID_W-1:0] MY_IDX = ncst_pkg::ID_W'(IDX);

    logic                                r_used;
    logic [ncst_pkg::NAME_W-1:0]         r_name;
    logic signed [ncst_pkg::COUNT_W-1:0] r_count;
    ncst_pkg::t_tok                      r_tok;

    logic                                n_used;
    logic [ncst_pkg::NAME_W-1:0]         n_name;
    logic signed [ncst_pkg::COUNT_W-1:0] n_count;
    ncst_pkg::t_tok                      n_tok;

    always_comb begin
        n_used  = r_used;
        n_name  = r_name;
        n_count = r_count;
        n_tok   = i_tok;
        if (i_tok.valid) begin
            unique case (i_tok.kind)
                ncst_pkg::KIND_CREATE: begin
                    if (r_used && r_name == i_tok.name && !i_tok.found) begin
                        n_tok.found     = 1'b1;
                        n_tok.found_idx = MY_IDX;
                    end
                    if (!r_used && !i_tok.free) begin
                        n_tok.free     = 1'b1;
                        n_tok.free_idx = MY_IDX;
                    end
                end
                ncst_pkg::KIND_SET: begin
                    if (r_used && i_tok.sem_id == MY_IDX) begin
                        n_count     = i_tok.new_count;
                        n_tok.done  = 1'b1;
                        n_tok.value = i_tok.new_count;
                    end
                end
                ncst_pkg::KIND_WAIT: begin
                    if (r_used && i_tok.sem_id == MY_IDX) begin
                        if (r_count != ncst_pkg::COUNT_MIN) begin
                            n_count = r_count - 16'sd1;
                        end
                        n_tok.done  = 1'b1;
                        n_tok.value = '0;
                        n_tok.block = n_count < 0;
                    end
                end
                ncst_pkg::KIND_SIGNAL: begin
                    if (r_used && i_tok.sem_id == MY_IDX) begin
                        if (r_count != ncst_pkg::COUNT_MAX) begin
                            n_count = r_count + 16'sd1;
                        end
                        n_tok.done  = 1'b1;
                        n_tok.value = '0;
                        n_tok.wake  = n_count <= 0;
                    end
                end
                default: begin
                end
            endcase
        end
        // A claim only arrives when no token is in the chain.
        if (i_claim.valid && i_claim.idx == MY_IDX) begin
            n_used  = 1'b1;
            n_name  = i_claim.name;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_name  <= '0;
            r_count <= '0;
            r_tok   <= '0;
        end else begin
            r_used  <= n_used;
            r_name  <= n_name;
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

// ----- sv/named_counting_semaphore_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// named_counting_semaphore_table_unit: table of named counting semaphores
// Each accepted item walks the cell chain one cell per cycle; its result
// and done strobe are registered as the token leaves the last cell. A new
// item is taken only after the last one has left the chain; busy is
// high while the chain holds an item. The receiver cannot stall. A
// synchronous active-low reset empties every entry at once.
// ----------------------------------------------------------------------------
module named_counting_semaphore_table_unit #(
    parameter int NUM_SEMAPHORES = ncst_pkg::NUM_SEMAPHORES_DEF,
    parameter int NAME_BYTES     = ncst_pkg::NAME_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_sem_id,
    input  wire logic [63:0] i_sem_name,
    input  wire logic signed [15:0] i_new_count,
    output logic             o_done,
    output logic             o_status,
    output logic signed [15:0] o_ret_value,
    output logic             o_must_block,
    output logic             o_wake_one
);

    // Token entering cell 0, and the chain of tokens between cells.
    ncst_pkg::t_tok   w_head;
    ncst_pkg::t_tok   w_tok [0:NUM_SEMAPHORES];
    ncst_pkg::t_claim w_claim;
    ncst_pkg::t_tok   w_last;
    logic [63:0]      w_name;

    logic                r_busy;
    logic                r_done;
    logic                r_status;
    logic signed [15:0]  r_ret_value;
    logic                r_must_block;
    logic                r_wake_one;

    logic                n_status;
    logic signed [15:0]  n_ret_value;
    logic                n_must_block;
    logic                n_wake_one;

    // Cut the name at its first zero byte and at NAME_BYTES bytes; every byte
    // from the cut upward reads as zero, so compare and store see one form.
    always_comb begin
        logic       alive;
        logic [7:0] nb;
        alive  = 1'b1;
        w_name = '0;
        for (int b = 0; b < 8; b++) begin
            nb = i_sem_name[8*b +: 8];
            if (b < NAME_BYTES && alive && nb != 8'd0) begin
                w_name[8*b +: 8] = nb;
            end else begin
                alive = 1'b0;
            end
        end
    end

    // A fresh token starts with no match, no free entry and nothing applied.
    always_comb begin
        w_head           = '0;
        w_head.valid     = start && !r_busy;
        w_head.kind      = ncst_pkg::t_kind'(i_kind);
        w_head.sem_id    = i_sem_id;
        w_head.name      = w_name;
        w_head.new_count = i_new_count;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < NUM_SEMAPHORES; g++) begin : g_cell
        ncst_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_claim (w_claim),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last = w_tok[NUM_SEMAPHORES];

    // When the token leaves the last cell, the whole table has been seen.
    // A create that found no matching name claims the lowest free entry by
    // broadcasting its index; the result and the claim land on the same edge.
    always_comb begin
        w_claim       = '0;
        n_status      = ncst_pkg::STATUS_FAIL;
        n_ret_value   = ncst_pkg::FAIL_VALUE;
        n_must_block  = 1'b0;
        n_wake_one    = 1'b0;
        if (w_last.kind == ncst_pkg::KIND_CREATE) begin
            if (w_last.found) begin
                n_status    = ncst_pkg::STATUS_OK;
                n_ret_value = 16'(w_last.found_idx);
            end else if (w_last.free) begin
                n_status      = ncst_pkg::STATUS_OK;
                n_ret_value   = 16'(w_last.free_idx);
                w_claim.valid = w_last.valid;
                w_claim.idx   = w_last.free_idx;
                w_claim.name  = w_last.name;
            end
        end else if (w_last.done) begin
            n_status     = ncst_pkg::STATUS_OK;
            n_ret_value  = w_last.value;
            n_must_block = w_last.block;
            n_wake_one   = w_last.wake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (w_last.valid) begin
                r_busy <= 1'b0;
            end else if (start && !r_busy) begin
                r_busy <= 1'b1;
            end
            r_done <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_status     <= n_status;
            r_ret_value  <= n_ret_value;
            r_must_block <= n_must_block;
            r_wake_one   <= n_wake_one;
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_ret_value  = r_ret_value;
    assign o_must_block = r_must_block;
    assign o_wake_one   = r_wake_one;

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for named_counting_semaphore_table_unit
// Directed requests cover failing ids, name cutting, claiming, count
// saturation and a full table. Then about 500 random requests follow, in three
// phases with different sender pacing. A tracker class keeps its own copy of
// the table, predicts each reply and checks replies as the block strobes them.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSEM       = ncst_pkg::NUM_SEMAPHORES_DEF;
    localparam int NAME_BYTES = ncst_pkg::NAME_BYTES_DEF;

    typedef struct {
        logic                                status;
        logic signed [ncst_pkg::COUNT_W-1:0] value;
        logic                                block;
        logic                                wake;
    } t_sem_reply;

    // Shadow table of the semaphores plus the replies still owed by the block.
    class t_sem_table_tracker;
        logic                                entry_used  [NSEM];
        logic [ncst_pkg::NAME_W-1:0]         entry_name  [NSEM];
        logic signed [ncst_pkg::COUNT_W-1:0] entry_count [NSEM];
        t_sem_reply                          expected_replies [$];
        int                                  errors;

        function new();
            foreach (entry_used[i]) begin
                entry_used[i]  = 1'b0;
                entry_name[i]  = '0;
                entry_count[i] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // A name ends at its first zero byte; only NAME_BYTES bytes count.
        function logic [ncst_pkg::NAME_W-1:0] trim_name(
                logic [ncst_pkg::NAME_W-1:0] raw);
            logic [ncst_pkg::NAME_W-1:0] kept;
            kept = '0;
            for (int b = 0; b < NAME_BYTES; b++) begin
                if (raw[8*b +: 8] == 8'h00)
                    break;
                kept[8*b +: 8] = raw[8*b +: 8];
            end
            return kept;
        endfunction

        function void note_request(ncst_pkg::t_kind kind,
                                   logic [ncst_pkg::ID_W-1:0] id,
                                   logic [ncst_pkg::NAME_W-1:0] raw_name,
                                   logic signed [ncst_pkg::COUNT_W-1:0] load);
            t_sem_reply                          r;
            logic [ncst_pkg::NAME_W-1:0]         nm;
            logic signed [ncst_pkg::COUNT_W-1:0] c;
            int                                  hit;
            r.status = ncst_pkg::STATUS_FAIL;
            r.value  = ncst_pkg::FAIL_VALUE;
            r.block  = 1'b0;
            r.wake   = 1'b0;
            if (kind == ncst_pkg::KIND_CREATE) begin
                nm  = trim_name(raw_name);
                hit = -1;
                for (int i = 0; i < NSEM; i++)
                    if (hit < 0 && entry_used[i] && entry_name[i] == nm)
                        hit = i;
                // No match: claim the lowest free entry, its count starts at zero.
                for (int i = 0; i < NSEM; i++)
                    if (hit < 0 && !entry_used[i]) begin
                        hit            = i;
                        entry_used[i]  = 1'b1;
                        entry_name[i]  = nm;
                        entry_count[i] = '0;
                    end
                if (hit >= 0) begin
                    r.status = ncst_pkg::STATUS_OK;
                    r.value  = ncst_pkg::COUNT_W'(hit);
                end
            end else if (id < NSEM && entry_used[id]) begin
                r.status = ncst_pkg::STATUS_OK;
                r.value  = '0;
                c        = entry_count[id];
                case (kind)
                    ncst_pkg::KIND_SET: begin
                        c       = load;
                        r.value = load;
                    end
                    ncst_pkg::KIND_WAIT: begin
                        if (c != ncst_pkg::COUNT_MIN)
                            c = c - 16'sd1;
                        r.block = (c < 0);
                    end
                    ncst_pkg::KIND_SIGNAL: begin
                        if (c != ncst_pkg::COUNT_MAX)
                            c = c + 16'sd1;
                        r.wake = (c <= 0);
                    end
                    default: ;
                endcase
                entry_count[id] = c;
            end
            expected_replies.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        task check_reply(logic status, logic signed [ncst_pkg::COUNT_W-1:0] value,
                         logic block, logic wake);
            t_sem_reply want;
            if (expected_replies.size() == 0) begin
                report("reply strobed with no request outstanding");
                return;
            end
            want = expected_replies.pop_front();
            if (status !== want.status)
                report($sformatf("status got %b want %b", status, want.status));
            if (value !== want.value)
                report($sformatf("ret_value got %0d want %0d", value, want.value));
            if (block !== want.block)
                report($sformatf("must_block got %b want %b", block, want.block));
            if (wake !== want.wake)
                report($sformatf("wake_one got %b want %b", wake, want.wake));
        endtask
    endclass

    logic                                i_clk;
    logic                                i_rst_n  = 1'b0;
    logic                                start    = 1'b0;
    logic                                busy;
    ncst_pkg::t_kind                     req_kind = ncst_pkg::KIND_CREATE;
    logic [ncst_pkg::ID_W-1:0]           req_id   = '0;
    logic [ncst_pkg::NAME_W-1:0]         req_name = '0;
    logic signed [ncst_pkg::COUNT_W-1:0] req_load = '0;
    logic                                o_done;
    logic                                o_status;
    logic signed [ncst_pkg::COUNT_W-1:0] o_ret_value;
    logic                                o_must_block;
    logic                                o_wake_one;

    t_sem_table_tracker sb = new();

    // Names held by the table once the directed part has filled it.
    logic [ncst_pkg::NAME_W-1:0] known_names [NSEM];

    named_counting_semaphore_table_unit #(
        .NUM_SEMAPHORES (NSEM),
        .NAME_BYTES     (NAME_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (req_kind),
        .i_sem_id     (req_id),
        .i_sem_name   (req_name),
        .i_new_count  (req_load),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_ret_value  (o_ret_value),
        .o_must_block (o_must_block),
        .o_wake_one   (o_wake_one)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Replies are checked before a request accepted at the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                sb.check_reply(o_status, o_ret_value, o_must_block, o_wake_one);
            if (start && !busy)
                sb.note_request(req_kind, req_id, req_name, req_load);
        end
    end

    task automatic send_request(ncst_pkg::t_kind kind,
                                logic [ncst_pkg::ID_W-1:0] id,
                                logic [ncst_pkg::NAME_W-1:0] nm,
                                logic signed [ncst_pkg::COUNT_W-1:0] load);
        start    <= 1'b1;
        req_kind <= kind;
        req_id   <= id;
        req_name <= nm;
        req_load <= load;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stops the sender until every outstanding reply has been checked.
    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Fills the bytes above a name's terminating zero with junk, which the
    // block must ignore.
    function automatic logic [ncst_pkg::NAME_W-1:0] pad_with_junk(
            logic [ncst_pkg::NAME_W-1:0] nm);
        logic [ncst_pkg::NAME_W-1:0] junk;
        int                          len;
        junk = {$urandom, $urandom};
        len  = 8;
        for (int b = 0; b < 8; b++)
            if (len == 8 && nm[8*b +: 8] == 8'h00)
                len = b;
        for (int b = len + 1; b < 8; b++)
            nm[8*b +: 8] = junk[8*b +: 8];
        return nm;
    endfunction

    task automatic run_random(int count, int idle_pct);
        ncst_pkg::t_kind                     kind;
        logic [ncst_pkg::ID_W-1:0]           id;
        logic [ncst_pkg::NAME_W-1:0]         nm;
        logic signed [ncst_pkg::COUNT_W-1:0] load;
        int                                  roll;
        logic [ncst_pkg::ID_W-1:0]           focus_id;
        focus_id = ncst_pkg::ID_W'($urandom_range(0, NSEM - 1));
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            kind = (roll < 20) ? ncst_pkg::KIND_CREATE :
                   (roll < 40) ? ncst_pkg::KIND_SET :
                   (roll < 70) ? ncst_pkg::KIND_WAIT : ncst_pkg::KIND_SIGNAL;
            // Most requests hammer one entry so counts reach their limits.
            if ($urandom_range(0, 9) == 0)
                focus_id = ncst_pkg::ID_W'($urandom_range(0, NSEM - 1));
            roll = $urandom_range(0, 99);
            if (roll < 60)
                id = focus_id;
            else if (roll < 88)
                id = ncst_pkg::ID_W'($urandom_range(0, NSEM - 1));
            else if (roll < 96)
                id = ncst_pkg::ID_W'($urandom_range(NSEM, 255));
            else
                id = ncst_pkg::ID_W'($urandom);
            nm   = {$urandom, $urandom};
            load = ncst_pkg::COUNT_W'($urandom);
            roll = $urandom_range(0, 99);
            if (kind == ncst_pkg::KIND_CREATE) begin
                if (roll < 65)
                    nm = pad_with_junk(known_names[$urandom_range(0, NSEM - 1)]);
                else if (roll < 80)
                    nm[7:0] = 8'hFE;    // first byte unused by any stored name
            end else if (kind == ncst_pkg::KIND_SET) begin
                if (roll < 30) begin
                    case ($urandom_range(0, 6))
                        0: load = ncst_pkg::COUNT_MAX;
                        1: load = ncst_pkg::COUNT_MAX - 16'sd1;
                        2: load = ncst_pkg::COUNT_MIN;
                        3: load = ncst_pkg::COUNT_MIN + 16'sd1;
                        4: load = '0;
                        5: load = -16'sd1;
                        default: load = 16'sd1;
                    endcase
                end else if (roll < 60) begin
                    load = ncst_pkg::COUNT_W'(int'($urandom_range(0, 8)) - 4);
                end
            end
            send_request(kind, id, nm, load);
            if ($urandom_range(0, 99) < idle_pct)
                hold_off($urandom_range(1, 40));
        end
    endtask

    initial begin
        logic [ncst_pkg::NAME_W-1:0] nm;
        int                          len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ids that are unused or out of range fail with no state change.
        send_request(ncst_pkg::KIND_WAIT,   8'd3,   '0, '0);
        send_request(ncst_pkg::KIND_SIGNAL, 8'd16,  '0, '0);
        send_request(ncst_pkg::KIND_SET,    8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd5);
        // The all-zero name is valid; a zero first byte cuts to it as well.
        known_names[0] = '0;
        send_request(ncst_pkg::KIND_CREATE, 8'hFF, 64'h0, ncst_pkg::COUNT_MIN);
        send_request(ncst_pkg::KIND_CREATE, 8'h00, 64'h8000_0000_0000_0000, '0);
        // An embedded zero byte truncates the name before compare and store.
        known_names[1] = 64'h0000_0000_4455_6677;
        send_request(ncst_pkg::KIND_CREATE, 8'h00, 64'h1122_3300_4455_6677, '0);
        send_request(ncst_pkg::KIND_CREATE, 8'h00, 64'h0000_0000_4455_6677, '0);
        known_names[2] = 64'hFFFF_FFFF_FFFF_FFFF;
        send_request(ncst_pkg::KIND_CREATE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        // Saturation at both ends of the count.
        send_request(ncst_pkg::KIND_SET,    8'd1, '0, ncst_pkg::COUNT_MAX);
        send_request(ncst_pkg::KIND_SIGNAL, 8'd1, '0, '0);
        send_request(ncst_pkg::KIND_SET,    8'd1, '0, ncst_pkg::COUNT_MIN);
        send_request(ncst_pkg::KIND_WAIT,   8'd1, '0, '0);
        // Crossing zero in both directions.
        send_request(ncst_pkg::KIND_SET,    8'd2, '0, '0);
        send_request(ncst_pkg::KIND_WAIT,   8'd2, '0, '0);
        send_request(ncst_pkg::KIND_SIGNAL, 8'd2, '0, '0);
        send_request(ncst_pkg::KIND_SIGNAL, 8'd2, '0, '0);
        // Fill the rest of the table with names of every length.
        for (int j = 3; j < NSEM; j++) begin
            nm       = '0;
            nm[7:0]  = 8'(j);
            len      = (j % 8) + 1;
            for (int b = 1; b < len; b++)
                nm[8*b +: 8] = 8'($urandom_range(1, 255));
            known_names[j] = nm;
            send_request(ncst_pkg::KIND_CREATE, 8'(j), pad_with_junk(nm), '0);
        end
        // Full table: a new name fails, a known one is still found.
        send_request(ncst_pkg::KIND_CREATE, 8'h00, 64'h0000_0000_0000_00FE, '0);
        send_request(ncst_pkg::KIND_CREATE, 8'h00, 64'h0000_0000_0000_0000, '0);
        drain_replies();

        run_random(170, 14);
        drain_replies();
        run_random(170, 80);
        drain_replies();
        run_random(160, 0);
        drain_replies();

        repeat (NSEM + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
